// ----- sv/mouse_click_drag_classifier_unit_macros.svh -----
// Assertion macros for the mouse click/drag classifier unit.
// Define ASSERT_OFF to compile all checks out; no other dependencies.
`ifndef MOUSE_CLICK_DRAG_CLASSIFIER_UNIT_MACROS_SVH
`define MOUSE_CLICK_DRAG_CLASSIFIER_UNIT_MACROS_SVH

`ifndef ASSERT_OFF

// Clocked check, disabled while reset is high.
`define MCDC_ASSERT(name, clk, rst, prop, msg) \
   name: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked check that also holds during reset.
`define MCDC_ASSERT_ALWAYS(name, clk, prop, msg) \
   name: assert property (@(posedge clk) prop) else $error(msg);

`else

`define MCDC_ASSERT(name, clk, rst, prop, msg)
`define MCDC_ASSERT_ALWAYS(name, clk, prop, msg)

`endif

`endif

// ----- sv/mcdc_pkg.sv -----
// Package for the mouse click/drag classifier: beat types, register indexes,
// reset values and event bit positions. No dependencies.
`default_nettype none

package mcdc_pkg;

   // Input beat: one per frame tick
   typedef struct packed {
      logic [31:0]        time_now;
      logic signed [15:0] pos_x;
      logic signed [15:0] pos_y;
      logic               left_down;
      logic               middle_down;
      logic               right_down;
      logic               wheel_up;
      logic               wheel_down;
   } req_type;

   // Result beat
   typedef struct packed {
      logic [17:0] event_mask;
      logic [31:0] left_hold_ms;
   } rsp_type;

   localparam int unsigned CSR_INDEX_W = 2;
   localparam int unsigned CSR_DATA_W  = 16;

   typedef enum logic [CSR_INDEX_W-1:0] {
      REG_CLICK_MAX  = 2'd0,
      REG_MOVE_TOL   = 2'd1,
      REG_REPEAT     = 2'd2,
      REG_DBL_CLICK  = 2'd3
   } csr_index_type;

   localparam logic [15:0] CLICK_MAX_RESET = 16'd500;
   localparam logic [7:0]  MOVE_TOL_RESET  = 8'd4;
   localparam logic [15:0] REPEAT_RESET    = 16'd1000;
   localparam logic [15:0] DBL_RESET       = 16'd500;

   localparam int unsigned NUM_BTN = 3;
   localparam int unsigned BTN_L   = 0;
   localparam int unsigned BTN_M   = 1;
   localparam int unsigned BTN_R   = 2;

   // Event mask bit positions
   localparam logic [4:0] EV_MOVE    = 5'd0;
   localparam logic [4:0] EV_LCLICK  = 5'd3;
   localparam logic [4:0] EV_LDBL    = 5'd4;
   localparam logic [4:0] EV_LDRAG   = 5'd5;
   localparam logic [4:0] EV_LREPEAT = 5'd6;
   localparam logic [4:0] EV_RDRAG   = 5'd15;
   localparam logic [4:0] EV_WHEELUP = 5'd16;
   localparam logic [4:0] EV_WHEELDN = 5'd17;

   // Per-button positions, indexed left, middle, right
   localparam logic [4:0] EV_DOWN [NUM_BTN] = '{5'd1, 5'd7, 5'd11};
   localparam logic [4:0] EV_UP   [NUM_BTN] = '{5'd2, 5'd8, 5'd12};
   localparam logic [4:0] EV_CLK  [NUM_BTN] = '{5'd3, 5'd9, 5'd13};
   localparam logic [4:0] EV_DBL  [NUM_BTN] = '{5'd4, 5'd10, 5'd14};

endpackage

`default_nettype wire

// ----- sv/mouse_click_drag_classifier_unit.sv -----
// Mouse click/drag classifier, top level. Depends on mcdc_pkg and the
// assertion macros header.
// Each accepted req beat gives its rsp beat in the next cycle, from the output register.
// Throughput: one beat per cycle; the single output register sets the rate,
//   and req_ready stays high while the rsp beat is taken in the same cycle.
// Reset (synchronous, active high): config registers to their defaults,
//   pointer/button/timestamp history to zero, output register empty.
`default_nettype none

`include "mouse_click_drag_classifier_unit_macros.svh"

module mouse_click_drag_classifier_unit (
   input  wire logic                                clock,
   input  wire logic                                reset,
   // request channel
   input  wire logic                                req_valid,
   output logic                                     req_ready,
   input  wire mcdc_pkg::req_type                   req_data,
   // response channel
   output logic                                     rsp_valid,
   input  wire logic                                rsp_ready,
   output mcdc_pkg::rsp_type                        rsp_data,
   // config writes
   input  wire logic                                csr_write,
   input  wire logic [mcdc_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  wire logic [mcdc_pkg::CSR_DATA_W-1:0]     csr_wdata
);
   import mcdc_pkg::*;

   // ---------------------------------------------------------------
   // Config registers
   // ---------------------------------------------------------------
   logic [15:0] click_max_ff;
   logic [7:0]  move_tol_ff;
   logic [15:0] repeat_ff;
   logic [15:0] dbl_click_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         click_max_ff <= CLICK_MAX_RESET;
         move_tol_ff  <= MOVE_TOL_RESET;
         repeat_ff    <= REPEAT_RESET;
         dbl_click_ff <= DBL_RESET;
      end else if (csr_write) begin
         case (csr_index_type'(csr_index))
            REG_CLICK_MAX: click_max_ff <= csr_wdata;
            REG_MOVE_TOL:  move_tol_ff  <= csr_wdata[7:0];
            REG_REPEAT:    repeat_ff    <= csr_wdata;
            REG_DBL_CLICK: dbl_click_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // ---------------------------------------------------------------
   // Handshake: the output register frees up when its beat is taken,
   // so a new req beat can land in the same cycle.
   // ---------------------------------------------------------------
   logic    rsp_valid_ff;
   rsp_type rsp_data_ff;
   logic    req_fire;

   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign req_fire  = req_valid && req_ready;

   // ---------------------------------------------------------------
   // History state
   // ---------------------------------------------------------------
   logic [15:0]        prev_x_ff, prev_x_in;
   logic [15:0]        prev_y_ff, prev_y_in;
   logic [NUM_BTN-1:0] prev_btn_ff, prev_btn_in;
   logic [31:0]        press_time_ff [NUM_BTN];
   logic [31:0]        press_time_in [NUM_BTN];
   logic [31:0]        last_click_ff [NUM_BTN];
   logic [31:0]        last_click_in [NUM_BTN];
   // press position, entry 0 left, entry 1 right
   logic [15:0]        press_x_ff [2];
   logic [15:0]        press_x_in [2];
   logic [15:0]        press_y_ff [2];
   logic [15:0]        press_y_in [2];

   rsp_type            rsp_in;

   // ---------------------------------------------------------------
   // Classification, all in one pass against the stored history
   // ---------------------------------------------------------------
   always_comb begin
      logic               moved;
      logic [NUM_BTN-1:0] cur;
      logic [17:0]        mask;
      logic [31:0]        hold;
      logic [31:0]        press_age [NUM_BTN];
      logic [31:0]        click_age [NUM_BTN];
      logic signed [16:0] dx [2];
      logic signed [16:0] dy [2];
      logic [16:0]        adx [2];
      logic [16:0]        ady [2];
      logic [NUM_BTN-1:0] near;
      logic               click;

      prev_x_in   = req_data.pos_x;
      prev_y_in   = req_data.pos_y;
      cur         = {req_data.right_down, req_data.middle_down, req_data.left_down};
      prev_btn_in = cur;
      press_time_in = press_time_ff;
      last_click_in = last_click_ff;
      press_x_in    = press_x_ff;
      press_y_in    = press_y_ff;

      moved = (req_data.pos_x != prev_x_ff) || (req_data.pos_y != prev_y_ff);
      mask  = '0;
      hold  = '0;
      mask[EV_MOVE] = moved;

      // Press-to-release offset per axis, exact 17-bit signed difference
      for (int k = 0; k < 2; k++) begin
         dx[k]  = $signed({press_x_ff[k][15], press_x_ff[k]})
                - $signed({req_data.pos_x[15], req_data.pos_x});
         dy[k]  = $signed({press_y_ff[k][15], press_y_ff[k]})
                - $signed({req_data.pos_y[15], req_data.pos_y});
         adx[k] = dx[k][16] ? 17'(-dx[k]) : 17'(dx[k]);
         ady[k] = dy[k][16] ? 17'(-dy[k]) : 17'(dy[k]);
      end
      // middle button has no position tolerance
      near[BTN_L] = (adx[0] <= {9'd0, move_tol_ff}) && (ady[0] <= {9'd0, move_tol_ff});
      near[BTN_M] = 1'b1;
      near[BTN_R] = (adx[1] <= {9'd0, move_tol_ff}) && (ady[1] <= {9'd0, move_tol_ff});

      for (int b = 0; b < NUM_BTN; b++) begin
         press_age[b] = req_data.time_now - press_time_ff[b];
         click_age[b] = req_data.time_now - last_click_ff[b];
         click = 1'b0;
         if (!prev_btn_ff[b] && cur[b]) begin
            mask[EV_DOWN[b]] = 1'b1;
            press_time_in[b] = req_data.time_now;
         end
         if (prev_btn_ff[b] && !cur[b]) begin
            mask[EV_UP[b]] = 1'b1;
            click = (press_age[b] < {16'd0, click_max_ff}) && near[b];
         end
         if (click) begin
            mask[EV_CLK[b]] = 1'b1;
            mask[EV_DBL[b]] = click_age[b] < {16'd0, dbl_click_ff};
            last_click_in[b] = req_data.time_now;
         end
      end

      if (!prev_btn_ff[BTN_L] && cur[BTN_L]) begin
         press_x_in[0] = req_data.pos_x;
         press_y_in[0] = req_data.pos_y;
      end
      if (!prev_btn_ff[BTN_R] && cur[BTN_R]) begin
         press_x_in[1] = req_data.pos_x;
         press_y_in[1] = req_data.pos_y;
      end

      // Left held across both ticks: hold time, drag and auto-repeat
      if (cur[BTN_L] && prev_btn_ff[BTN_L]) begin
         hold             = press_age[BTN_L];
         mask[EV_LDRAG]   = moved;
         mask[EV_LREPEAT] = hold > {16'd0, repeat_ff};
      end
      mask[EV_RDRAG]    = cur[BTN_R] && prev_btn_ff[BTN_R] && moved;
      mask[EV_WHEELUP]  = req_data.wheel_up;
      mask[EV_WHEELDN]  = req_data.wheel_down;

      rsp_in.event_mask   = mask;
      rsp_in.left_hold_ms = hold;
   end

   // History updates only on an accepted req beat
   always_ff @(posedge clock) begin
      if (reset) begin
         prev_x_ff   <= '0;
         prev_y_ff   <= '0;
         prev_btn_ff <= '0;
         for (int b = 0; b < NUM_BTN; b++) begin
            press_time_ff[b] <= '0;
            last_click_ff[b] <= '0;
         end
         for (int k = 0; k < 2; k++) begin
            press_x_ff[k] <= '0;
            press_y_ff[k] <= '0;
         end
      end else if (req_fire) begin
         prev_x_ff     <= prev_x_in;
         prev_y_ff     <= prev_y_in;
         prev_btn_ff   <= prev_btn_in;
         press_time_ff <= press_time_in;
         last_click_ff <= last_click_in;
         press_x_ff    <= press_x_in;
         press_y_ff    <= press_y_in;
      end
   end

   // ---------------------------------------------------------------
   // Output register
   // ---------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (req_fire) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         rsp_data_ff <= rsp_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // ---------------------------------------------------------------
   // Checks
   // ---------------------------------------------------------------
   `MCDC_ASSERT(a_dbl_needs_click, clock, reset, rsp_valid_ff && rsp_data_ff.event_mask[EV_LDBL] |-> rsp_data_ff.event_mask[EV_LCLICK], "left double click without click")
   `MCDC_ASSERT(a_hold_needs_left, clock, reset, req_fire && !req_data.left_down |=> rsp_data_ff.left_hold_ms == 32'd0, "left hold time nonzero with left released")
   `MCDC_ASSERT(a_no_overrun, clock, reset, rsp_valid_ff && !rsp_ready |-> !req_ready, "req beat accepted over a stalled rsp beat")
   `MCDC_ASSERT_ALWAYS(a_reset_empty, clock, $past(reset) |-> !rsp_valid_ff, "rsp valid right after reset")

endmodule

`default_nettype wire

// ----- sim/tb_mouse_click_drag_classifier_unit.sv -----
// Self-checking bench for mouse_click_drag_classifier_unit: directed and random
// frame ticks, checked against a cycle-free scoreboard model of the classifier.
// Depends on mcdc_pkg and the RTL only.
`default_nettype none

module tb_mouse_click_drag_classifier_unit;
   import mcdc_pkg::*;

   // ------------------------------------------------------------------
   // Scoreboard: mirrors the classifier state and register file, turns
   // each accepted tick into the expected event beat and compares the
   // beats coming out of the block in order.
   // ------------------------------------------------------------------
   class click_scoreboard;
      logic [15:0]        click_max_ms;
      logic [7:0]         move_tol;
      logic [15:0]        repeat_ms;
      logic [15:0]        dbl_window_ms;
      logic signed [15:0] last_x;
      logic signed [15:0] last_y;
      logic [2:0]         last_btn;
      logic [31:0]        press_ms [NUM_BTN];
      logic signed [15:0] press_x [2];
      logic signed [15:0] press_y [2];
      logic [31:0]        click_ms [NUM_BTN];
      rsp_type            predicted_q [$];
      int                 errors;
      int                 ticks;
      int                 clicks;
      int                 doubles;
      int                 repeats;
      int                 drags;

      function new();
         click_max_ms  = CLICK_MAX_RESET;
         move_tol      = MOVE_TOL_RESET;
         repeat_ms     = REPEAT_RESET;
         dbl_window_ms = DBL_RESET;
         last_x        = '0;
         last_y        = '0;
         last_btn      = '0;
         for (int b = 0; b < NUM_BTN; b++) begin
            press_ms[b] = '0;
            click_ms[b] = '0;
         end
         for (int k = 0; k < 2; k++) begin
            press_x[k] = '0;
            press_y[k] = '0;
         end
      endfunction

      function void write_register(csr_index_type idx, logic [15:0] val);
         case (idx)
            REG_CLICK_MAX: click_max_ms  = val;
            REG_MOVE_TOL:  move_tol      = val[7:0];
            REG_REPEAT:    repeat_ms     = val;
            REG_DBL_CLICK: dbl_window_ms = val;
            default: ;
         endcase
      endfunction

      function void note_tick(req_type t);
         logic [2:0]  now_btn;
         logic [17:0] mask;
         logic [31:0] hold;
         logic [31:0] since;
         bit          moved;
         bit          click;
         int          k;
         int          dx;
         int          dy;
         rsp_type     beat;
         now_btn = {t.right_down, t.middle_down, t.left_down};
         mask    = '0;
         hold    = '0;
         moved   = (t.pos_x != last_x) || (t.pos_y != last_y);
         mask[EV_MOVE] = moved;
         for (int b = 0; b < NUM_BTN; b++) begin
            if (!last_btn[b] && now_btn[b]) begin
               mask[EV_DOWN[b]] = 1'b1;
               press_ms[b] = t.time_now;
               if (b != BTN_M) begin
                  k = (b == BTN_L) ? 0 : 1;
                  press_x[k] = t.pos_x;
                  press_y[k] = t.pos_y;
               end
            end
            if (last_btn[b] && !now_btn[b]) begin
               mask[EV_UP[b]] = 1'b1;
               since = t.time_now - press_ms[b];
               click = since < {16'd0, click_max_ms};
               if (b != BTN_M) begin
                  k  = (b == BTN_L) ? 0 : 1;
                  dx = int'($signed(press_x[k])) - int'($signed(t.pos_x));
                  dy = int'($signed(press_y[k])) - int'($signed(t.pos_y));
                  if (dx < 0) dx = -dx;
                  if (dy < 0) dy = -dy;
                  click = click && dx <= int'(move_tol) && dy <= int'(move_tol);
               end
               if (click) begin
                  mask[EV_CLK[b]] = 1'b1;
                  clicks++;
                  since = t.time_now - click_ms[b];
                  if (since < {16'd0, dbl_window_ms}) begin
                     mask[EV_DBL[b]] = 1'b1;
                     doubles++;
                  end
                  click_ms[b] = t.time_now;
               end
            end
         end
         if (now_btn[BTN_L] && last_btn[BTN_L]) begin
            hold = t.time_now - press_ms[BTN_L];
            mask[EV_LDRAG] = moved;
            mask[EV_LREPEAT] = hold > {16'd0, repeat_ms};
         end
         mask[EV_RDRAG]    = now_btn[BTN_R] && last_btn[BTN_R] && moved;
         mask[EV_WHEELUP]  = t.wheel_up;
         mask[EV_WHEELDN]  = t.wheel_down;
         if (mask[EV_LREPEAT]) repeats++;
         if (mask[EV_LDRAG] || mask[EV_RDRAG]) drags++;
         last_x   = t.pos_x;
         last_y   = t.pos_y;
         last_btn = now_btn;
         ticks++;
         beat.event_mask   = mask;
         beat.left_hold_ms = hold;
         predicted_q = {predicted_q, beat};
      endfunction

      function void check_result(rsp_type got);
         rsp_type want;
         if (predicted_q.size() == 0) begin
            errors++;
            $display("%0t: unexpected beat, expected none, actual mask %05h hold %0d",
                     $time, got.event_mask, got.left_hold_ms);
            return;
         end
         want = predicted_q.pop_front();
         if (got.event_mask !== want.event_mask) begin
            errors++;
            $display("%0t: event_mask mismatch, expected %05h, actual %05h",
                     $time, want.event_mask, got.event_mask);
         end
         if (got.left_hold_ms !== want.left_hold_ms) begin
            errors++;
            $display("%0t: left_hold_ms mismatch, expected %0d, actual %0d",
                     $time, want.left_hold_ms, got.left_hold_ms);
         end
      endfunction
   endclass

   // ------------------------------------------------------------------
   // Clock, reset and block I/O. Every input has a known value at time 0.
   // ------------------------------------------------------------------
   logic          clock     = 1'b0;
   logic          reset     = 1'b1;
   logic          req_valid = 1'b0;
   logic          req_ready;
   req_type       req_data  = '0;
   logic          rsp_valid;
   logic          rsp_ready = 1'b0;
   rsp_type       rsp_data;
   logic          csr_write = 1'b0;
   csr_index_type csr_index = REG_CLICK_MAX;
   logic [15:0]   csr_wdata = '0;

   click_scoreboard sb = new();

   // Random-walk pointer state for the random part
   logic [31:0]        walk_ms;
   logic signed [15:0] walk_x;
   logic signed [15:0] walk_y;
   logic [2:0]         walk_btn;

   bit          calm          = 1'b0; // no idling on either side while set
   int unsigned stall_request = 0;    // long receiver hold-off, taken once
   int          settings_used = 1;    // reset defaults count as the first

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   mouse_click_drag_classifier_unit u_top (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_write (csr_write),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // Hard stop, several times the slowest legal run.
   initial begin
      #400000;
      $display("mouse_click_drag_classifier_unit verification failed");
      $finish;
   end

   // Monitor: sampled at the edge, before any NBA of this step lands, so the
   // handshakes are seen exactly as the block sees them. Tick noted first.
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && req_ready) sb.note_tick(req_data);
         if (rsp_valid && rsp_ready) sb.check_result(rsp_data);
      end
   end

   // Wait before a beat: mostly none, sometimes a random wait drawn per beat.
   function automatic int unsigned draw_wait();
      if (calm) return 0;
      return ($urandom_range(0, 2) == 0) ? $urandom_range(1, 12) : 0;
   endfunction

   // Receiver: stalls per beat on its own, plus a long hold-off on request
   // so the single output register fills and req_ready drops.
   initial begin
      int unsigned stall;
      forever begin
         stall = draw_wait();
         if (stall_request != 0) begin
            stall = stall_request;
            stall_request = 0;
         end
         if (stall > 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!rsp_valid);
      end
   end

   // Offer one tick; returns at the edge it is taken. Valid stays up into
   // the next beat unless that beat starts with a gap.
   task automatic send_tick(req_type t);
      int unsigned gap;
      gap = draw_wait();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= t;
      do @(posedge clock); while (!req_ready);
   endtask

   // Back-to-back writes of all four registers; block must be idle.
   task automatic apply_settings(logic [15:0] cm, logic [15:0] tol,
                                 logic [15:0] rep, logic [15:0] dbl);
      csr_index_type order [4];
      logic [15:0]   vals [4];
      order = '{REG_CLICK_MAX, REG_MOVE_TOL, REG_REPEAT, REG_DBL_CLICK};
      vals  = '{cm, tol, rep, dbl};
      for (int i = 0; i < 4; i++) begin
         csr_write <= 1'b1;
         csr_index <= order[i];
         csr_wdata <= vals[i];
         sb.write_register(order[i], vals[i]);
         @(posedge clock);
      end
      csr_write <= 1'b0;
      settings_used++;
   endtask

   // Wait one edge so the monitor has noted the last tick, then for every
   // predicted beat, then a margin for the output register.
   task automatic drain_events();
      req_valid <= 1'b0;
      @(posedge clock);
      while (sb.predicted_q.size() != 0) @(posedge clock);
      repeat (3) @(posedge clock);
   endtask

   function automatic req_type make_tick(logic [31:0] ms, logic signed [15:0] x,
                                         logic signed [15:0] y, bit l, bit m,
                                         bit r, bit wu, bit wd);
      req_type t;
      t.time_now    = ms;
      t.pos_x       = x;
      t.pos_y       = y;
      t.left_down   = l;
      t.middle_down = m;
      t.right_down  = r;
      t.wheel_up    = wu;
      t.wheel_down  = wd;
      return t;
   endfunction

   // Mostly plausible pointer traffic: small time steps, jitter of a few
   // pixels, buttons toggling now and then. About 8% is pure noise.
   function automatic req_type next_walk_tick();
      if ($urandom_range(0, 99) < 8) begin
         walk_ms  = $urandom;
         walk_x   = 16'($urandom);
         walk_y   = 16'($urandom);
         walk_btn = 3'($urandom);
      end else begin
         if ($urandom_range(0, 9) == 0) walk_ms += $urandom_range(200, 1600);
         else walk_ms += $urandom_range(0, 120);
         if ($urandom_range(0, 49) == 0) begin
            walk_x = 16'($urandom);
            walk_y = 16'($urandom);
         end else if ($urandom_range(0, 2) != 0) begin
            walk_x += 16'($urandom_range(0, 6)) - 16'd3;
            walk_y += 16'($urandom_range(0, 6)) - 16'd3;
         end
         if ($urandom_range(0, 4) == 0) walk_btn[BTN_L] = ~walk_btn[BTN_L];
         if ($urandom_range(0, 7) == 0) walk_btn[BTN_M] = ~walk_btn[BTN_M];
         if ($urandom_range(0, 5) == 0) walk_btn[BTN_R] = ~walk_btn[BTN_R];
      end
      return make_tick(walk_ms, walk_x, walk_y, walk_btn[BTN_L], walk_btn[BTN_M],
                       walk_btn[BTN_R], $urandom_range(0, 7) == 0,
                       $urandom_range(0, 7) == 0);
   endfunction

   // ------------------------------------------------------------------
   // Main sequence
   // ------------------------------------------------------------------
   initial begin
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // Directed ticks, reset register values.
      // First tick compares against position zero: no move.
      send_tick(make_tick(32'd10, 0, 0, 0, 0, 0, 0, 0));
      send_tick(make_tick(32'd20, 5, 0, 0, 0, 0, 0, 0));
      // Left click right after reset: last click time is zero, so it is
      // also reported as a double click.
      send_tick(make_tick(32'd30, 5, 0, 1, 0, 0, 0, 0));
      send_tick(make_tick(32'd100, 5, 0, 0, 0, 0, 0, 0));
      // Middle click across the whole coordinate range: no tolerance check.
      send_tick(make_tick(32'd200, -32768, 32767, 0, 1, 0, 0, 0));
      send_tick(make_tick(32'd300, 32767, -32768, 0, 0, 0, 0, 0));
      // Right press with both wheel flags, drag, release within tolerance.
      send_tick(make_tick(32'd400, 32767, -32768, 0, 0, 1, 1, 1));
      send_tick(make_tick(32'd420, 32764, -32768, 0, 0, 1, 0, 0));
      send_tick(make_tick(32'd450, 32764, -32764, 0, 0, 0, 0, 1));
      // Long left hold: drag, then auto-repeat once hold passes 1000 ms.
      send_tick(make_tick(32'd1000, 0, 0, 1, 0, 0, 1, 0));
      send_tick(make_tick(32'd1500, 3, 3, 1, 0, 0, 0, 0));
      send_tick(make_tick(32'd2000, 3, 3, 1, 0, 0, 0, 0));
      send_tick(make_tick(32'd2001, 3, 3, 1, 0, 0, 0, 0));
      send_tick(make_tick(32'd2100, 3, 3, 0, 0, 0, 0, 0));
      // Quick release just outside the tolerance: no click.
      send_tick(make_tick(32'd2200, 100, 100, 1, 0, 0, 0, 0));
      send_tick(make_tick(32'd2300, 105, 100, 0, 0, 0, 0, 0));
      // Release at the tolerance edge: click, then a genuine double click.
      send_tick(make_tick(32'd2400, 100, 100, 1, 0, 0, 0, 0));
      send_tick(make_tick(32'd2450, 104, 96, 0, 0, 0, 0, 0));
      send_tick(make_tick(32'd2500, 104, 96, 1, 0, 0, 0, 0));
      send_tick(make_tick(32'd2600, 104, 96, 0, 0, 0, 0, 0));
      // Timestamp wrap during a left hold and click.
      send_tick(make_tick(32'hFFFF_FF00, 104, 96, 1, 0, 0, 0, 0));
      send_tick(make_tick(32'h0000_0050, 104, 96, 1, 0, 0, 0, 0));
      send_tick(make_tick(32'h0000_0060, 104, 96, 0, 0, 0, 0, 0));
      // All-ones corner: every button, both wheels, then everything released.
      send_tick(make_tick(32'hFFFF_FFFF, -1, -1, 1, 1, 1, 1, 1));
      send_tick(make_tick(32'h0000_0100, -1, -1, 0, 0, 0, 0, 0));
      drain_events();

      walk_ms  = 32'h0000_0200;
      walk_x   = -1;
      walk_y   = -1;
      walk_btn = '0;

      // Random phases, each with its own register setting:
      // 0 reset values, 1 tight, 2 all zero, 3 all max, 4..6 random.
      for (int phase = 0; phase < 7; phase++) begin
         case (phase)
            1: apply_settings(16'd300, 16'd2, 16'd600, 16'd400);
            2: apply_settings(16'd0, 16'd0, 16'd0, 16'd0);
            3: apply_settings(16'hFFFF, {8'($urandom), 8'hFF}, 16'hFFFF, 16'hFFFF);
            4, 5, 6: apply_settings(16'($urandom_range(1, 1500)),
                                    {8'($urandom), 8'($urandom_range(0, 12))},
                                    16'($urandom_range(0, 2500)),
                                    16'($urandom_range(1, 1200)));
            default: ;
         endcase
         calm = (phase == 1) || (phase == 4);
         for (int i = 0; i < 200; i++) begin
            // Receiver backs off for a long stretch while ticks keep coming.
            if (i == 100 && (phase == 2 || phase == 5)) stall_request = 64;
            send_tick(next_walk_tick());
         end
         calm = 1'b0;
         drain_events();
      end

      $display("Run covered %0d ticks over %0d register settings, incl. wrap and corners.",
               sb.ticks, settings_used);
      $display("Seen %0d clicks, %0d double clicks, %0d repeat beats, %0d drag beats.",
               sb.clicks, sb.doubles, sb.repeats, sb.drags);
      if (sb.errors == 0 && sb.predicted_q.size() == 0) begin
         $display("mouse_click_drag_classifier_unit verification clean");
      end else begin
         $display("mouse_click_drag_classifier_unit verification failed");
      end
      $finish;
   end

endmodule

`default_nettype wire

// ----- files.f -----
+incdir+sv
sv/mcdc_pkg.sv
sv/mouse_click_drag_classifier_unit.sv
sim/tb_mouse_click_drag_classifier_unit.sv
